FILE: hdl/htw_pkg.sv
// Shared types and constants for the tree-walk Huffman decoder.
// No dependencies; imported by the front end, the walker and the top level.
package htw_pkg;

    // fixed field widths
    localparam int IDX_W  = 9;
    localparam int SYM_W  = 21;
    localparam int BYTE_W = 8;
    localparam int PAD_W  = 3;
    localparam int NBIT_W = 4;

    // command codes on the item channel
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_FINAL = 2'd2;

    // one input item
    typedef struct packed {
        logic [1:0]        cmd;
        logic [IDX_W-1:0]  node_index;
        logic [IDX_W-1:0]  node_left;
        logic [IDX_W-1:0]  node_right;
        logic [SYM_W-1:0]  node_symbol;
        logic [BYTE_W-1:0] data_byte;
        logic [PAD_W-1:0]  pad_bits;
    } item_t;

    // one result item
    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             last_of_byte;
        logic             end_of_stream;
    } result_t;

    // classified operation handed from front to back
    typedef enum logic {
        OP_LOAD,
        OP_BYTE
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic              final_byte;
        logic [IDX_W-1:0]  index;
        logic [IDX_W-1:0]  left;
        logic [IDX_W-1:0]  right;
        logic [SYM_W-1:0]  symbol;
        logic [BYTE_W-1:0] data;
        logic [NBIT_W-1:0] nbits;
    } op_t;

endpackage

FILE: hdl/htw_fifo.sv
// Small register queue used between the decoder stages and on the result side.
// No package dependencies.
module htw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/htw_front.sv
// Front end: takes items, classifies them and queues operations for the walker.
// Depends on htw_pkg and htw_fifo.
module htw_front
    import htw_pkg::*;
#(
    parameter int NODE_COUNT = 512,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item,
    input  logic  push,
    output logic  full,
    output op_t   op,
    output logic  op_valid,
    input  logic  op_pop
);

    op_t  op_in;
    logic keep;
    logic op_empty;
    logic [$bits(op_t)-1:0] op_bits;

    // classify the incoming item
    always_comb
    begin
        op_in.kind       = OP_BYTE;
        op_in.final_byte = 1'b0;
        op_in.index      = item.node_index;
        op_in.left       = item.node_left;
        op_in.right      = item.node_right;
        op_in.symbol     = item.node_symbol;
        op_in.data       = item.data_byte;
        op_in.nbits      = NBIT_W'(BYTE_W);
        keep             = 1'b0;
        unique case (item.cmd)
            CMD_LOAD:
            begin
                op_in.kind = OP_LOAD;
                // loads beyond the store are dropped
                keep = (32'(item.node_index) < NODE_COUNT);
            end
            CMD_DATA:
            begin
                keep = 1'b1;
            end
            CMD_FINAL:
            begin
                op_in.final_byte = 1'b1;
                op_in.nbits      = NBIT_W'(BYTE_W) - NBIT_W'(item.pad_bits);
                keep             = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // operation queue between front and back
    htw_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .wdata (op_in),
        .full  (full),
        .pop   (op_pop),
        .rdata (op_bits),
        .empty (op_empty)
    );

    assign op       = op_t'(op_bits);
    assign op_valid = !op_empty;

endmodule

FILE: hdl/htw_back.sv
// Back end: node store and bit-serial tree walker, one bit per cycle unless a full result queue stalls it.
// Depends on htw_pkg.
module htw_back
    import htw_pkg::*;
#(
    parameter int NODE_COUNT  = 512,
    parameter int SYMBOL_BITS = 21
) (
    input  logic    clk,
    input  logic    rst_n,
    input  op_t     op,
    input  logic    op_valid,
    output logic    op_pop,
    output logic    out_push,
    output result_t out_result,
    input  logic    out_full
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int SW = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [SW-1:0]    sym;
    } node_t;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t            state_reg;
    node_t             store [NODE_COUNT];
    node_t             rd_data_reg;
    logic              rd_pend_reg;
    logic              rd_oor_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  cur_idx_reg;
    logic [IDX_W-1:0]  cur_left_reg;
    logic [IDX_W-1:0]  cur_right_reg;
    logic [IDX_W-1:0]  root_left_reg;
    logic [IDX_W-1:0]  root_right_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [NBIT_W-1:0] bits_left_reg;
    logic              final_reg;
    logic              held_valid_reg;
    logic [SW-1:0]     held_sym_reg;

    node_t             rd_node;
    logic              leaf;
    logic              stall;
    logic              resolve;
    logic              issue;
    logic              finish;
    logic              load_wr;
    logic [IDX_W-1:0]  eff_idx;
    logic [IDX_W-1:0]  eff_left;
    logic [IDX_W-1:0]  eff_right;
    logic [IDX_W-1:0]  next_idx;
    logic              next_oor;

    // resolve the registered node read that is still pending
    assign rd_node = rd_oor_reg ? '0 : rd_data_reg;
    assign leaf    = rd_pend_reg && (rd_node.sym != '0);
    assign stall   = leaf && held_valid_reg && out_full;
    assign resolve = rd_pend_reg && !stall;

    // node the walk stands on after this cycle's resolve
    always_comb
    begin
        eff_idx   = cur_idx_reg;
        eff_left  = cur_left_reg;
        eff_right = cur_right_reg;
        if (resolve)
        begin
            if (leaf)
            begin
                eff_idx   = '0;
                eff_left  = root_left_reg;
                eff_right = root_right_reg;
            end
            else
            begin
                eff_idx   = rd_idx_reg;
                eff_left  = rd_node.left;
                eff_right = rd_node.right;
            end
        end
    end

    // next bit, msb first
    assign next_idx = byte_reg[BYTE_W-1] ? eff_right : eff_left;
    assign next_oor = !(32'(next_idx) < NODE_COUNT);
    assign issue    = (state_reg == S_WALK) && (bits_left_reg != '0) && !stall;
    assign finish   = (state_reg == S_WALK) && (bits_left_reg == '0) && !rd_pend_reg
                      && !(held_valid_reg && out_full);
    assign op_pop   = (state_reg == S_IDLE) && op_valid;
    assign load_wr  = op_pop && (op.kind == OP_LOAD);

    // results leave one step late so the last one of a byte can be flagged
    always_comb
    begin
        out_push                 = 1'b0;
        out_result.out_symbol    = SYM_W'(held_sym_reg);
        out_result.last_of_byte  = 1'b0;
        out_result.end_of_stream = 1'b0;
        if (resolve && leaf && held_valid_reg)
        begin
            out_push = 1'b1;
        end
        else if (finish && held_valid_reg)
        begin
            out_push                 = 1'b1;
            out_result.last_of_byte  = 1'b1;
            out_result.end_of_stream = final_reg;
        end
    end

    // node store: written by loads, read once per walked bit
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            store[AW'(op.index)] <= '{left: op.left,
                                      right: op.right,
                                      sym: SW'(op.symbol)};
        end
        if (issue)
        begin
            rd_data_reg <= store[AW'(next_idx)];
        end
    end

    // walk payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg <= next_idx;
            rd_oor_reg <= next_oor;
        end
        if (resolve && leaf)
        begin
            held_sym_reg <= rd_node.sym;
        end
        if (load_wr && (op.index == '0))
        begin
            root_left_reg  <= op.left;
            root_right_reg <= op.right;
        end
    end

    // walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_pend_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
            cur_idx_reg    <= '0;
            cur_left_reg   <= '0;
            cur_right_reg  <= '0;
            byte_reg       <= '0;
            bits_left_reg  <= '0;
            final_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (op_pop)
                    begin
                        if (op.kind == OP_LOAD)
                        begin
                            // keep the cached children of the current node fresh
                            if (op.index == cur_idx_reg)
                            begin
                                cur_left_reg  <= op.left;
                                cur_right_reg <= op.right;
                            end
                        end
                        else
                        begin
                            byte_reg      <= op.data;
                            bits_left_reg <= op.nbits;
                            final_reg     <= op.final_byte;
                            state_reg     <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    if (resolve)
                    begin
                        cur_idx_reg   <= eff_idx;
                        cur_left_reg  <= eff_left;
                        cur_right_reg <= eff_right;
                        if (leaf)
                        begin
                            held_valid_reg <= 1'b1;
                        end
                    end
                    if (issue)
                    begin
                        byte_reg      <= {byte_reg[BYTE_W-2:0], 1'b0};
                        bits_left_reg <= bits_left_reg - 1'b1;
                        rd_pend_reg   <= 1'b1;
                    end
                    else if (resolve)
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                    if (finish)
                    begin
                        held_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                        // a final byte always leaves the walk at the root
                        if (final_reg)
                        begin
                            cur_idx_reg   <= '0;
                            cur_left_reg  <= root_left_reg;
                            cur_right_reg <= root_right_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a node read is only in flight while a byte is walked
    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_WALK))
        else $error("node read pending outside a walk");

    // the walker never pushes into a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result transfer into full queue");

    // a resolved leaf is always held for output next cycle
    a_leaf_held: assert property (@(posedge clk) disable iff (!rst_n)
        (resolve && leaf) |=> held_valid_reg)
        else $error("decoded symbol lost");

    // bit count never exceeds one byte
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= NBIT_W'(BYTE_W))
        else $error("bit count out of range");

endmodule

FILE: hdl/huffman_tree_walk_decoder.sv
// Top level of the tree-walk Huffman decoder: front end, walker, result queue.
// Depends on htw_pkg, htw_fifo, htw_front and htw_back.
//
// Usage:
//   Items enter through a queue-style port: an item transfers on a rising edge
//   with push high and full low. A load item writes one node of the code tree;
//   a data item carries eight code bits, msb first; a final data item drops its
//   pad_bits low bits and leaves the walk at the root afterwards.
//   Results leave through a queue-style port: the oldest result is on result
//   while empty is low and transfers on an edge with pop high.
// Timing:
//   A load is written to the node store as it is taken from the operation queue.
//   A data byte passes through its bit steps, a read resolve, a close-out and a
//   dispatch; the loop through the node store read port sets the one-bit-per-cycle
//   pace unless a full result queue holds a symbol back. A symbol waits for the next
//   one of its byte or for close-out before it is pushed; the last one at close-out.
//   A short operation queue lets items keep arriving while a byte is walked.
// Reset:
//   Queues empty and the walk at the root; the node store holds nothing
//   defined until loaded. When pop stays low the result queue fills, the walker
//   pauses, then the operation queue fills and full rises; nothing is dropped.
module huffman_tree_walk_decoder
    import htw_pkg::*;
#(
    parameter int NODE_COUNT  = 512,
    parameter int SYMBOL_BITS = 21
) (
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    push,
    output logic    full,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    op_t     op;
    logic    op_valid;
    logic    op_pop;
    logic    res_push;
    result_t res_in;
    logic    res_full;
    logic [$bits(result_t)-1:0] res_bits;

    // intake and classification
    htw_front #(
        .NODE_COUNT  (NODE_COUNT),
        .QUEUE_DEPTH (2)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .full     (full),
        .op       (op),
        .op_valid (op_valid),
        .op_pop   (op_pop)
    );

    // node store and walker
    htw_back #(
        .NODE_COUNT  (NODE_COUNT),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .op_valid   (op_valid),
        .op_pop     (op_pop),
        .out_push   (res_push),
        .out_result (res_in),
        .out_full   (res_full)
    );

    // result queue
    htw_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign result = result_t'(res_bits);

endmodule

FILE: tb/sv/huffman_tree_walk_decoder_test.sv
// Self-checking testbench for the tree-walk Huffman decoder: code trees are loaded,
// bytes are walked, and every symbol is checked against an in-bench tree walk.
// Depends on htw_pkg and the huffman_tree_walk_decoder RTL only.
module huffman_tree_walk_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import htw_pkg::*;

    localparam int NODES        = 512;
    localparam int UNICODE_MAX  = 1114111;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int REPORT_MAX   = 10;

    // command code that the block ignores
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    item_t   item  = '0;
    logic    push  = 1'b0;
    logic    full;
    result_t result;
    logic    empty;
    logic    pop   = 1'b0;

    // predicted code tree and walk position
    logic [IDX_W-1:0] tree_left  [NODES];
    logic [IDX_W-1:0] tree_right [NODES];
    logic [SYM_W-1:0] tree_sym   [NODES];
    logic [IDX_W-1:0] walk_node;
    result_t          expected_symbols[$];

    // node indexes claimed by the tree under construction
    bit taken [NODES];

    int errors          = 0;
    int loads_sent      = 0;
    int bytes_sent      = 0;
    int symbols_checked = 0;
    int cycle_count     = 0;
    int send_idle_odds  = 0;
    int pop_idle_odds   = 0;

    huffman_tree_walk_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .full   (full),
        .result (result),
        .empty  (empty),
        .pop    (pop)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d symbols still expected",
                     cycle_count, expected_symbols.size());
            $display("huffman_tree_walk_decoder_test: done, errors");
            $finish;
        end
    end

    task automatic note_failure(input string what);
        errors++;
        if (errors <= REPORT_MAX)
            $display("FAIL @%0t: %s", $realtime, what);
    endtask

    // walk the predicted tree for one accepted item
    task automatic predict_item(input item_t it);
        result_t          fresh_syms[$];
        result_t          r;
        logic [IDX_W-1:0] next_node;
        int               walked;
        if (it.cmd == CMD_LOAD)
        begin
            tree_left[it.node_index]  = it.node_left;
            tree_right[it.node_index] = it.node_right;
            tree_sym[it.node_index]   = it.node_symbol;
            loads_sent++;
        end
        else if (it.cmd == CMD_DATA || it.cmd == CMD_FINAL)
        begin
            walked = (it.cmd == CMD_FINAL) ? BYTE_W - int'(it.pad_bits) : BYTE_W;
            for (int b = 0; b < walked; b++)
            begin
                next_node = it.data_byte[BYTE_W - 1 - b] ? tree_right[walk_node]
                                                          : tree_left[walk_node];
                if (tree_sym[next_node] != '0)
                begin
                    r.out_symbol    = tree_sym[next_node];
                    r.last_of_byte  = 1'b0;
                    r.end_of_stream = 1'b0;
                    fresh_syms.push_back(r);
                    walk_node = '0;
                end
                else
                begin
                    walk_node = next_node;
                end
            end
            // flag the closing symbol of the byte
            if (fresh_syms.size() > 0)
            begin
                r = fresh_syms.pop_back();
                r.last_of_byte  = 1'b1;
                r.end_of_stream = (it.cmd == CMD_FINAL);
                fresh_syms.push_back(r);
            end
            if (it.cmd == CMD_FINAL)
                walk_node = '0;
            foreach (fresh_syms[k])
                expected_symbols.push_back(fresh_syms[k]);
            bytes_sent++;
        end
    endtask

    // one item transfer, with an optional idle burst ahead of it
    task automatic send_item(input item_t it);
        if (send_idle_odds > 0 && $urandom_range(0, send_idle_odds - 1) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        predict_item(it);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_symbols.size() == 0)
        begin
            note_failure($sformatf("unexpected result: symbol %h last %b eos %b",
                                   got.out_symbol, got.last_of_byte, got.end_of_stream));
        end
        else
        begin
            want = expected_symbols.pop_front();
            symbols_checked++;
            if (got.out_symbol !== want.out_symbol ||
                got.last_of_byte !== want.last_of_byte ||
                got.end_of_stream !== want.end_of_stream)
                note_failure($sformatf(
                    "symbol exp %h got %h, last exp %b got %b, eos exp %b got %b",
                    want.out_symbol, got.out_symbol, want.last_of_byte,
                    got.last_of_byte, want.end_of_stream, got.end_of_stream));
        end
    endtask

    // result side: transfer check and random pop stalls
    initial
    begin : result_checker
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_result(result);
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (pop_idle_odds > 0 && $urandom_range(0, pop_idle_odds - 1) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    function automatic item_t random_item();
        item_t it;
        it.cmd         = 2'($urandom_range(0, 3));
        it.node_index  = IDX_W'($urandom_range(0, NODES - 1));
        it.node_left   = IDX_W'($urandom_range(0, NODES - 1));
        it.node_right  = IDX_W'($urandom_range(0, NODES - 1));
        it.node_symbol = SYM_W'($urandom_range(0, (1 << SYM_W) - 1));
        it.data_byte   = BYTE_W'($urandom_range(0, 255));
        it.pad_bits    = PAD_W'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic item_t make_load(input int idx, input int l, input int r,
                                        input int sym);
        item_t it;
        it             = random_item();
        it.cmd         = CMD_LOAD;
        it.node_index  = IDX_W'(idx);
        it.node_left   = IDX_W'(l);
        it.node_right  = IDX_W'(r);
        it.node_symbol = SYM_W'(sym);
        return it;
    endfunction

    function automatic item_t make_byte(input logic [1:0] cmd, input int data, input int pad);
        item_t it;
        it           = random_item();
        it.cmd       = cmd;
        it.data_byte = BYTE_W'(data);
        it.pad_bits  = PAD_W'(pad);
        return it;
    endfunction

    function automatic int fresh_index();
        int k;
        do
            k = $urandom_range(1, NODES - 1);
        while (taken[k]);
        taken[k] = 1'b1;
        return k;
    endfunction

    // leaf symbols mostly in code point range, sometimes using all 21 bits
    function automatic int random_symbol();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(1, (1 << SYM_W) - 1);
        return $urandom_range(1, UNICODE_MAX);
    endfunction

    // full binary tree rooted at node 0, loaded in shuffled order
    task automatic load_random_tree(input int leaf_count, input bit deep);
        int    open_q[$];
        int    inner_q[$];
        int    plan_l [NODES];
        int    plan_r [NODES];
        item_t loads[$];
        item_t tmp;
        int    pick;
        int    n;
        int    j;
        foreach (taken[k])
            taken[k] = 1'b0;
        taken[0] = 1'b1;
        inner_q.push_back(0);
        plan_l[0] = fresh_index();
        plan_r[0] = fresh_index();
        open_q.push_back(plan_l[0]);
        open_q.push_back(plan_r[0]);
        // split leaves until the count is reached; deep trees grow one chain
        for (int k = 2; k < leaf_count; k++)
        begin
            pick = deep ? open_q.size() - 1 : $urandom_range(0, open_q.size() - 1);
            n = open_q[pick];
            open_q.delete(pick);
            inner_q.push_back(n);
            plan_l[n] = fresh_index();
            plan_r[n] = fresh_index();
            open_q.push_back(plan_l[n]);
            open_q.push_back(plan_r[n]);
        end
        foreach (inner_q[k])
            loads.push_back(make_load(inner_q[k], plan_l[inner_q[k]], plan_r[inner_q[k]], 0));
        // leaf children are never followed but still point at loaded nodes
        foreach (open_q[k])
            loads.push_back(make_load(open_q[k],
                                      inner_q[$urandom_range(0, inner_q.size() - 1)],
                                      inner_q[$urandom_range(0, inner_q.size() - 1)],
                                      random_symbol()));
        for (int k = loads.size() - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = loads[k];
            loads[k] = loads[j];
            loads[j] = tmp;
        end
        foreach (loads[k])
            send_item(loads[k]);
    endtask

    // mostly plain bytes, some final bytes, a few ignored commands
    task automatic send_bytes(input int count);
        item_t it;
        repeat (count)
        begin
            it = random_item();
            case ($urandom_range(0, 29))
                0:       it.cmd = CMD_SPARE;
                1, 2, 3: it.cmd = CMD_FINAL;
                default: it.cmd = CMD_DATA;
            endcase
            send_item(it);
        end
    endtask

    // hand-built tree: long zero loop, extreme indexes and symbols, padding
    task automatic test_directed_corners();
        send_idle_odds = 4;
        pop_idle_odds  = 4;
        send_item(make_load(0, 511, 1, 0));
        send_item(make_load(1, 2, 3, 0));
        send_item(make_load(2, 511, 511, 1));
        send_item(make_load(3, 3, 4, 0));
        send_item(make_load(4, 0, 0, (1 << SYM_W) - 1));
        send_item(make_load(511, 0, 0, UNICODE_MAX));
        // eight symbols from one byte
        send_item(make_byte(CMD_DATA, 8'h00, 0));
        // byte that ends inside the tree
        send_item(make_byte(CMD_DATA, 8'hFF, 0));
        // byte that completes no symbol
        send_item(make_byte(CMD_DATA, 8'h00, 0));
        // final byte with one bit walked
        send_item(make_byte(CMD_FINAL, 8'h80, 7));
        // final byte ending mid-code, no symbol
        send_item(make_byte(CMD_FINAL, 8'hC0, 6));
        send_item(make_byte(CMD_DATA, 8'hA5, 0));
        send_item(make_byte(CMD_FINAL, 8'h12, 0));
        send_item(make_byte(CMD_SPARE, 8'hFF, 7));
        // root with a symbol and a child pointing back at itself
        send_item(make_load(0, 0, 511, 5));
        send_item(make_byte(CMD_DATA, 8'h5A, 0));
        send_item(make_byte(CMD_FINAL, 8'h3C, 2));
    endtask

    // several random trees under random idling on both sides
    task automatic test_random_trees(input int phases);
        int odds [3] = '{0, 3, 6};
        repeat (phases)
        begin
            send_idle_odds = odds[$urandom_range(0, 2)];
            pop_idle_odds  = odds[$urandom_range(0, 2)];
            load_random_tree($urandom_range(2, 24), $urandom_range(0, 3) == 0);
            send_bytes($urandom_range(40, 55));
        end
    endtask

    // back-to-back transfers with no idling anywhere
    task automatic test_steady_stream();
        send_idle_odds = 0;
        pop_idle_odds  = 0;
        load_random_tree($urandom_range(8, 24), 1'b0);
        send_bytes(45);
    endtask

    initial
    begin
        foreach (tree_left[k])
        begin
            tree_left[k]  = '0;
            tree_right[k] = '0;
            tree_sym[k]   = '0;
        end
        walk_node = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_trees(5);
        test_steady_stream();
        push <= 1'b0;

        // drain outstanding symbols, then watch for strays
        while (expected_symbols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d node loads and %0d data bytes over 7 code trees",
                 loads_sent, bytes_sent);
        $display("checked %0d symbols, %0d failures", symbols_checked, errors);
        if (errors == 0)
            $display("huffman_tree_walk_decoder_test: done, clean");
        else
            $display("huffman_tree_walk_decoder_test: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
hdl/htw_pkg.sv
hdl/htw_fifo.sv
hdl/htw_front.sv
hdl/htw_back.sv
hdl/huffman_tree_walk_decoder.sv
tb/sv/huffman_tree_walk_decoder_test.sv
